// File: hdl/left_to_right_expression_evaluator_unit_assert.svh
// Assertion macros for the expression evaluator checker.
// Included by the checker file; needs no package.
`ifndef LEFT_TO_RIGHT_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define LEFT_TO_RIGHT_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while rst is high.
`define LREE_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lree check failed");

// Next-cycle implication, switched off while rst is high.
`define LREE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lree check failed");

`endif

// File: hdl/lree_pkg.sv
// Shared types, character codes and helpers for the expression evaluator.
// No dependencies; used by controller, datapath and top level.
package lree_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int VALUE_WIDTH        = 32;
   localparam int CHAR_WIDTH         = 8;
   localparam int DIGIT_WIDTH        = 4;

   localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_WIDTH-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_AFTER_PLUS,
      PH_FIRST_DIGITS,
      PH_AFTER_NUMBER,
      PH_AFTER_OPERATOR,
      PH_DIGITS
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHAR,
      ST_COMMIT,
      ST_ARITH,
      ST_APPLY,
      ST_FINISH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic                   load_digit;
      logic                   append_digit;
      logic [DIGIT_WIDTH-1:0] digit;
      logic                   commit_first;
      logic                   negate;
      logic                   add_sub;
      logic                   subtract;
      logic                   start;
      logic                   divide;
      logic                   take_result;
      logic                   load_out;
      logic                   out_error;
      logic                   clear;
   } cmd_type;

   typedef struct packed {
      logic arith_done;
      logic cur_zero;
      logic rsp_busy;
   } status_type;

   function automatic logic is_digit(input logic [CHAR_WIDTH-1:0] ch);
      return ch inside {[CH_ZERO:CH_NINE]};
   endfunction

   function automatic logic is_operator(input logic [CHAR_WIDTH-1:0] ch);
      return ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
   endfunction

   function automatic op_type op_of(input logic [CHAR_WIDTH-1:0] ch);
      op_type op;
      case (ch)
         CH_PLUS:  op = OP_ADD;
         CH_MINUS: op = OP_SUB;
         CH_STAR:  op = OP_MUL;
         default:  op = OP_DIV;
      endcase
      return op;
   endfunction

endpackage

// File: hdl/lree_muldiv.sv
// Iterative multiplier and signed divider, one bit per cycle.
// Depends on nothing; instantiated by the datapath.
module lree_muldiv #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  divide,
   input  logic [DATA_WIDTH-1:0] operand_a,
   input  logic [DATA_WIDTH-1:0] operand_b,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int CW = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  div_ff, div_in;
   logic                  neg_ff, neg_in;
   logic [DATA_WIDTH-1:0] x_ff, x_in;
   logic [DATA_WIDTH-1:0] y_ff, y_in;
   logic [DATA_WIDTH-1:0] r_ff, r_in;
   logic [DATA_WIDTH-1:0] mag_a, mag_b;
   logic [DATA_WIDTH:0]   trial, diff;

   assign mag_a = operand_a[DATA_WIDTH-1] ? '0 - operand_a : operand_a;
   assign mag_b = operand_b[DATA_WIDTH-1] ? '0 - operand_b : operand_b;
   assign trial = {r_ff, y_ff[DATA_WIDTH-1]};
   assign diff  = trial - {1'b0, x_ff};

   assign done   = busy_ff && (cnt_ff == CW'(DATA_WIDTH));
   assign result = div_ff ? (neg_ff ? '0 - y_ff : y_ff) : r_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = divide;
         neg_in  = operand_a[DATA_WIDTH-1] ^ operand_b[DATA_WIDTH-1];
         r_in    = '0;
         x_in    = divide ? mag_b : operand_a;
         y_in    = divide ? mag_a : operand_b;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (div_ff) begin
            // restoring step: subtract when the trial remainder allows
            if (!diff[DATA_WIDTH]) begin
               r_in = diff[DATA_WIDTH-1:0];
               y_in = {y_ff[DATA_WIDTH-2:0], 1'b1};
            end else begin
               r_in = trial[DATA_WIDTH-1:0];
               y_in = {y_ff[DATA_WIDTH-2:0], 1'b0};
            end
         end else begin
            r_in = r_ff + (y_ff[0] ? x_ff : '0);
            x_in = x_ff << 1;
            y_in = y_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      r_ff   <= r_in;
   end

endmodule

// File: hdl/lree_dp.sv
// Datapath: accumulator, number register, arithmetic unit, result register.
// Depends on lree_pkg and lree_muldiv.
module lree_dp #(
   parameter int DATA_WIDTH = lree_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lree_pkg::cmd_type                   cmd,
   output lree_pkg::status_type                status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lree_pkg::VALUE_WIDTH-1:0] rsp_value,
   output logic                                rsp_status
);

   import lree_pkg::*;

   logic [DATA_WIDTH-1:0]             acc_ff, acc_in;
   logic [DATA_WIDTH-1:0]             cur_ff, cur_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]            rsp_value_ff, rsp_value_in;
   logic                              rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0]             arith_result;
   logic                              arith_done;
   logic [VALUE_WIDTH+DATA_WIDTH-1:0] acc_wide;

   lree_muldiv #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start),
      .divide    (cmd.divide),
      .operand_a (acc_ff),
      .operand_b (cur_ff),
      .done      (arith_done),
      .result    (arith_result)
   );

   // low result bits, zero filled when the datapath is narrower
   assign acc_wide = {{VALUE_WIDTH{1'b0}}, acc_ff};

   always_comb begin
      acc_in = acc_ff;
      cur_in = cur_ff;
      if (cmd.clear) begin
         acc_in = '0;
         cur_in = '0;
      end else begin
         if (cmd.load_digit) begin
            cur_in = DATA_WIDTH'(cmd.digit);
         end else if (cmd.append_digit) begin
            cur_in = (cur_ff << 3) + (cur_ff << 1) + DATA_WIDTH'(cmd.digit);
         end
         if (cmd.commit_first) begin
            acc_in = cmd.negate ? '0 - cur_ff : cur_ff;
         end else if (cmd.add_sub) begin
            acc_in = cmd.subtract ? acc_ff - cur_ff : acc_ff + cur_ff;
         end else if (cmd.take_result) begin
            acc_in = arith_result;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.out_error;
         rsp_value_in  = cmd.out_error ? '0 : acc_wide[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff        <= acc_in;
      cur_ff        <= cur_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign status.arith_done = arith_done;
   assign status.cur_zero   = (cur_ff == '0);
   assign status.rsp_busy   = rsp_valid_ff;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: hdl/lree_ctrl.sv
// Controller: request handshake, parse phase and sequencing of the datapath.
// Depends on lree_pkg.
module lree_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lree_pkg::CHAR_WIDTH-1:0]     req_ch,
   input  logic                                req_last,
   output lree_pkg::cmd_type                   cmd,
   input  lree_pkg::status_type                status
);

   import lree_pkg::*;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   op_type                op_ff, op_in;
   logic                  negate_ff, negate_in;
   logic                  error_ff, error_in;
   logic                  stopped_ff, stopped_in;
   logic                  closing_ff, closing_in;
   logic [CHAR_WIDTH-1:0] ch_ff, ch_in;
   logic                  last_ff, last_in;
   logic                  active;

   assign active = !stopped_ff && !error_ff;

   // next state and control registers
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      op_in      = op_ff;
      negate_in  = negate_ff;
      error_in   = error_ff;
      stopped_in = stopped_ff;
      closing_in = closing_ff;
      ch_in      = ch_ff;
      last_in    = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ch_in      = req_ch;
               last_in    = req_last;
               closing_in = 1'b0;
               state_in   = ST_CHAR;
            end
         end
         ST_CHAR: begin
            if (active && is_digit(ch_ff)) begin
               case (phase_ff)
                  PH_FIRST_DIGITS, PH_DIGITS: ;
                  PH_START, PH_AFTER_PLUS:    phase_in = PH_FIRST_DIGITS;
                  PH_AFTER_OPERATOR:          phase_in = PH_DIGITS;
                  default:                    error_in = 1'b1;
               endcase
               state_in = ST_FINISH;
            end else if (active) begin
               state_in = ST_COMMIT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_COMMIT: begin
            case (phase_ff)
               PH_FIRST_DIGITS: begin
                  phase_in = PH_AFTER_NUMBER;
                  state_in = ST_APPLY;
               end
               PH_DIGITS: begin
                  if (op_ff == OP_MUL || (op_ff == OP_DIV && !status.cur_zero)) begin
                     state_in = ST_ARITH;
                  end else begin
                     if (op_ff == OP_DIV) begin
                        error_in = 1'b1;
                     end
                     phase_in = PH_AFTER_NUMBER;
                     state_in = ST_APPLY;
                  end
               end
               default: state_in = ST_APPLY;
            endcase
         end
         ST_ARITH: begin
            if (status.arith_done) begin
               phase_in = PH_AFTER_NUMBER;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (closing_ff) begin
               state_in = ST_RESULT;
            end else begin
               if (ch_ff == CH_NUL) begin
                  stopped_in = 1'b1;
               end else if (is_operator(ch_ff) && !error_ff) begin
                  case (phase_ff)
                     PH_START: begin
                        case (op_of(ch_ff))
                           OP_SUB:  negate_in = !negate_ff;
                           OP_ADD:  phase_in  = PH_AFTER_PLUS;
                           default: error_in  = 1'b1;
                        endcase
                     end
                     PH_AFTER_NUMBER: begin
                        op_in    = op_of(ch_ff);
                        phase_in = PH_AFTER_OPERATOR;
                     end
                     default: error_in = 1'b1;
                  endcase
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (error_ff) begin
               state_in = ST_RESULT;
            end else begin
               closing_in = 1'b1;
               state_in   = ST_COMMIT;
            end
         end
         ST_RESULT: begin
            if (!status.rsp_busy) begin
               phase_in   = PH_START;
               op_in      = OP_ADD;
               negate_in  = 1'b0;
               error_in   = 1'b0;
               stopped_in = 1'b0;
               closing_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      cmd.digit  = ch_ff[DIGIT_WIDTH-1:0];
      cmd.negate = negate_ff;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_CHAR: begin
            if (active && is_digit(ch_ff)) begin
               case (phase_ff)
                  PH_FIRST_DIGITS, PH_DIGITS: cmd.append_digit = 1'b1;
                  PH_START, PH_AFTER_PLUS, PH_AFTER_OPERATOR: cmd.load_digit = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_COMMIT: begin
            case (phase_ff)
               PH_FIRST_DIGITS: cmd.commit_first = 1'b1;
               PH_DIGITS: begin
                  case (op_ff)
                     OP_ADD, OP_SUB: begin
                        cmd.add_sub  = 1'b1;
                        cmd.subtract = (op_ff == OP_SUB);
                     end
                     OP_MUL: cmd.start = 1'b1;
                     default: begin
                        cmd.start  = !status.cur_zero;
                        cmd.divide = 1'b1;
                     end
                  endcase
               end
               default: ;
            endcase
         end
         ST_ARITH: cmd.take_result = status.arith_done;
         ST_RESULT: begin
            if (!status.rsp_busy) begin
               cmd.load_out  = 1'b1;
               cmd.out_error = error_ff || (phase_ff != PH_AFTER_NUMBER);
               cmd.clear     = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= PH_START;
         op_ff      <= OP_ADD;
         negate_ff  <= 1'b0;
         error_ff   <= 1'b0;
         stopped_ff <= 1'b0;
         closing_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         op_ff      <= op_in;
         negate_ff  <= negate_in;
         error_ff   <= error_in;
         stopped_ff <= stopped_in;
         closing_ff <= closing_in;
      end
      ch_ff   <= ch_in;
      last_ff <= last_in;
   end

endmodule

// File: hdl/left_to_right_expression_evaluator_unit.sv
// Top level of the left-to-right expression evaluator.
// Depends on lree_pkg, lree_ctrl, lree_dp (and lree_muldiv beneath it).
//
// Usage:
//  - Request channel (req_valid/req_ready, req_ch, req_last): one expression
//    byte per request; req_last marks the byte that closes the expression.
//  - Response channel (rsp_valid/rsp_ready, rsp_value, rsp_status): one
//    response per expression, after the request carrying req_last.
//    rsp_status 0 gives the value; 1 flags bad syntax, an empty expression
//    or division by zero, with rsp_value held at zero.
//  - Requests are handled one at a time. A byte that closes a multiply or
//    divide also waits for the one-bit-per-cycle unit. The request carrying
//    req_last then commits the final number (after an error it goes straight
//    to the response) before rsp_valid.
//  - The response register parts the two channels: a stalled receiver holds
//    the response stable while further requests are still taken; only the
//    next closing byte waits until the pending response has been taken.
//  - Reset (synchronous, active high) drops any pending response and returns
//    the parse state to the start of an expression. After every response the
//    block also returns to that state by itself.
module left_to_right_expression_evaluator_unit #(
   parameter int DATA_WIDTH = lree_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [lree_pkg::CHAR_WIDTH-1:0]         req_ch,
   input  logic                                    req_last,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [lree_pkg::VALUE_WIDTH-1:0] rsp_value,
   output logic                                    rsp_status
);

   import lree_pkg::*;

   cmd_type    cmd;
   status_type status;

   // parse state machine; drives the datapath by command
   lree_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .cmd       (cmd),
      .status    (status)
   );

   // number, accumulator, multiply/divide unit and response register
   lree_dp #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

endmodule

// File: hdl/lree_checker.sv
// Port-level checks for the expression evaluator, bound to the top level.
// Depends on lree_pkg and left_to_right_expression_evaluator_unit_assert.svh.
`include "left_to_right_expression_evaluator_unit_assert.svh"

module lree_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [lree_pkg::VALUE_WIDTH-1:0] rsp_value,
   input logic                                    rsp_status
);

   // hold the response while the receiver stalls
   `LREE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_status))

   // an error response carries a zero value
   `LREE_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && rsp_status, rsp_value == '0)

   // one request at a time: busy in the cycle after a request is taken
   `LREE_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   // a response is loaded only while the request side is closed
   `LREE_ASSERT_SAME(a_rsp_from_busy, clock, reset, $rose(rsp_valid), !$past(req_ready))

   // reset drops any pending response
   `LREE_ASSERT_NEXT(a_reset_drop, clock, 1'b0, reset, !rsp_valid)

endmodule

bind left_to_right_expression_evaluator_unit lree_checker u_lree_checker (.*);
